// ----- sv/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define DHS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// implication checked on every rising edge outside reset
`define DHS_ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) else $error(msg);
`else
`define DHS_ASSERT(lbl, clk, rstn, prop, msg)
`define DHS_ASSERT_IMP(lbl, clk, rstn, pre, post, msg)
`endif
`endif

// ----- sv/dhs_pkg.sv -----
// types, constants and the crc fold function of the dedup history store
package dhs_pkg;
  localparam int DEPTH_DEF         = 64;
  localparam int PAYLOAD_WIDTH_DEF = 32;
  localparam int IN_W              = 88;
  localparam int OUT_W             = 80;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [2:0] MODE_TEXT   = 3'd0;
  localparam logic [2:0] MODE_COMMIT = 3'd1;
  localparam logic [2:0] MODE_GET    = 3'd2;
  localparam logic [2:0] MODE_REMOVE = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_NRDY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ID_ZERO = 2'd0,
    ID_KEY  = 2'd1,
    ID_RD   = 2'd2
  } id_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_APPEND,
    S_GET_RD,
    S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    accept;
    logic    fold;
    logic    crc_restart;
    logic    key_crc;
    logic    key_in;
    logic    n_load;
    logic    idx_clear;
    logic    idx_inc;
    logic    rd_scan;
    logic    rd_shift;
    logic    rd_get;
    logic    wr_shift;
    logic    wr_append;
    logic    count_clear;
    logic    count_inc;
    logic    count_dec;
    logic    note;
    status_t note_status;
    id_sel_t note_id;
    logic    set_evict;
    logic    res_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic store_ready;
    logic out_free;
    logic count_zero;
    logic count_full;
    logic idx_last;
    logic shift_last;
    logic match;
    logic get_ok;
  } stat_t;

  // reflected crc-32 fold of one byte
  function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = (x >> 1) ^ (x[0] ? CRC_POLY : 32'd0);
    end
    return x;
  endfunction
endpackage

// ----- sv/dedup_history_store_crc32_top.sv -----
// Dedup history store keyed by a reflected CRC-32 message fingerprint.
// A text byte is folded into the CRC register as it is accepted. Table
// operations are run by a controller over an entry memory with one read
// port, one write port and registered read data: a commit reads and checks
// each stored entry for a duplicate, then moves each entry down when the
// oldest is evicted, then appends; a remove scans up to the match and moves
// each entry behind it down; a get reads one entry; clear and other
// operations go straight to the result. One result beat is held in an
// output register; while it waits unaccepted the controller stays in its
// done state, and the next item is accepted once the controller is idle again.
module dedup_history_store_crc32_top #(
  parameter int DEPTH         = dhs_pkg::DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = dhs_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // mode[2:0], data_byte[10:3], payload_tag[42:11], newest_index[48:43], key_id[80:49]
  input  logic [dhs_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // status[1:0], out_id[33:2], out_payload[65:34], entry_count[72:66], evicted[73]
  output logic [dhs_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_data
);
  import dhs_pkg::*;
`include "assert_macros.svh"

  cmd_t  cmd;
  stat_t st;
  logic  res_dup;
  logic  text_beat;
  logic  out_open;

  assign cfg_ready = 1'b1;

  // controller
  dhs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .mode      (in_tdata[2:0]),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath
  dhs_dp #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // terms used by the checks
  assign res_dup   = out_tvalid && (out_tdata[1:0] == ST_DUP);
  assign text_beat = in_tvalid && in_tready && (in_tdata[2:0] == MODE_TEXT);
  assign out_open  = !out_tvalid || out_tready;

  // checks
  `DHS_ASSERT(a_one_write, clk, rst_n, !(cmd.wr_shift && cmd.wr_append), "two memory writes")
  `DHS_ASSERT_IMP(a_dup_no_evict, clk, rst_n, res_dup, !out_tdata[73], "duplicate with eviction")
  `DHS_ASSERT_IMP(a_text_stays_idle, clk, rst_n, text_beat, ##1 in_tready, "text beat left idle")
  `DHS_ASSERT_IMP(a_load_free, clk, rst_n, cmd.res_load, out_open, "result overwritten")
endmodule

// ----- sv/dhs_ctrl.sv -----
// controller state machine of the dedup history store
module dhs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [2:0]    mode,
  input  dhs_pkg::stat_t st,
  output dhs_pkg::cmd_t  cmd
);
  import dhs_pkg::*;

  state_t state_r, state_nxt;
  logic   commit_r, commit_nxt;
  logic   acc;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  // state and operation registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      commit_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      commit_r <= commit_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    commit_nxt = commit_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (mode)
            MODE_TEXT: state_nxt = S_IDLE;
            MODE_COMMIT: begin
              commit_nxt = 1'b1;
              if (!st.store_ready) state_nxt = S_DONE;
              else if (st.count_zero) state_nxt = S_APPEND;
              else state_nxt = S_SCAN_RD;
            end
            MODE_GET: begin
              state_nxt = (st.store_ready && st.get_ok) ? S_GET_RD : S_DONE;
            end
            MODE_REMOVE: begin
              commit_nxt = 1'b0;
              state_nxt  = (st.store_ready && !st.count_zero) ? S_SCAN_RD : S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (st.match) begin
          if (commit_r) state_nxt = S_DONE;
          else if (st.idx_last) state_nxt = S_DONE;
          else state_nxt = S_SHIFT_RD;
        end else if (st.idx_last) begin
          if (!commit_r) state_nxt = S_DONE;
          else if (st.count_full) state_nxt = S_SHIFT_RD;
          else state_nxt = S_APPEND;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (st.shift_last) state_nxt = commit_r ? S_APPEND : S_DONE;
        else state_nxt = S_SHIFT_RD;
      end
      S_APPEND: state_nxt = S_DONE;
      S_GET_RD: state_nxt = S_DONE;
      S_DONE:   if (st.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd             = '0;
    cmd.note_status = ST_DONE;
    cmd.note_id     = ID_ZERO;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.accept = 1'b1;
          case (mode)
            MODE_TEXT: cmd.fold = 1'b1;
            MODE_COMMIT: begin
              cmd.crc_restart = 1'b1;
              cmd.note        = 1'b1;
              if (!st.store_ready) begin
                cmd.note_status = ST_NRDY;
              end else begin
                cmd.key_crc   = 1'b1;
                cmd.idx_clear = 1'b1;
              end
            end
            MODE_GET: begin
              cmd.n_load = 1'b1;
              cmd.note   = 1'b1;
              if (!st.store_ready) cmd.note_status = ST_NRDY;
              else if (!st.get_ok) cmd.note_status = ST_MISS;
              else cmd.note_id = ID_RD;
            end
            MODE_REMOVE: begin
              cmd.key_in      = 1'b1;
              cmd.idx_clear   = 1'b1;
              cmd.note        = 1'b1;
              cmd.note_status = st.store_ready ? ST_MISS : ST_NRDY;
            end
            MODE_CLEAR: begin
              cmd.note = 1'b1;
              if (!st.store_ready) cmd.note_status = ST_NRDY;
              else cmd.count_clear = 1'b1;
            end
            default: begin
              cmd.note        = 1'b1;
              cmd.note_status = ST_MISS;
            end
          endcase
        end
      end
      S_SCAN_RD: cmd.rd_scan = 1'b1;
      S_SCAN_CMP: begin
        if (st.match) begin
          cmd.note    = 1'b1;
          cmd.note_id = ID_KEY;
          if (commit_r) begin
            cmd.note_status = ST_DUP;
          end else if (st.idx_last) begin
            cmd.count_dec = 1'b1;
          end
        end else if (st.idx_last) begin
          if (commit_r && st.count_full) begin
            cmd.idx_clear = 1'b1;
            cmd.set_evict = 1'b1;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SHIFT_RD: cmd.rd_shift = 1'b1;
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (st.shift_last) cmd.count_dec = 1'b1;
      end
      S_APPEND: begin
        cmd.wr_append = 1'b1;
        cmd.count_inc = 1'b1;
        cmd.note      = 1'b1;
        cmd.note_id   = ID_KEY;
      end
      S_GET_RD: cmd.rd_get = 1'b1;
      S_DONE:   cmd.res_load = st.out_free;
      default:  cmd.accept = 1'b0;
    endcase
  end
endmodule

// ----- sv/dhs_dp.sv -----
// datapath of the dedup history store: crc, entry memory, counters, result register
module dhs_dp #(
  parameter int DEPTH         = dhs_pkg::DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = dhs_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [dhs_pkg::IN_W-1:0]   in_tdata,
  input  logic                       cfg_valid,
  input  logic                       cfg_data,
  input  dhs_pkg::cmd_t              cmd,
  output dhs_pkg::stat_t             st,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [dhs_pkg::OUT_W-1:0]  out_tdata
);
  import dhs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = CW + 1;

  // input fields
  logic [7:0]  in_byte;
  logic [31:0] in_tag;
  logic [5:0]  in_n;
  logic [31:0] in_key;
  assign in_byte = in_tdata[10:3];
  assign in_tag  = in_tdata[42:11];
  assign in_n    = in_tdata[48:43];
  assign in_key  = in_tdata[80:49];

  logic [31:0]            crc_r;
  logic                   ready_r;
  logic [CW-1:0]          count_r;
  logic [AW-1:0]          idx_r;
  logic [31:0]            key_r;
  logic [PAYLOAD_WIDTH-1:0] pay_r;
  logic [5:0]             n_r;
  logic                   evict_r;
  status_t                note_status_r;
  id_sel_t                note_id_r;
  logic [31:0]            rd_id_r;
  logic [PAYLOAD_WIDTH-1:0] rd_pay_r;
  logic                   out_valid_r;
  logic [OUT_W-1:0]       out_data_r;

  logic [31:0]            ids   [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] pays [DEPTH];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      ready_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) ready_r <= cfg_data;
      if (cmd.fold) crc_r <= crc_fold(crc_r, in_byte);
      else if (cmd.crc_restart) crc_r <= CRC_INIT;
      if (cmd.count_clear) count_r <= '0;
      else if (cmd.count_inc) count_r <= count_r + CW'(1);
      else if (cmd.count_dec) count_r <= count_r - CW'(1);
      if (cmd.res_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.key_crc) key_r <= crc_r ^ CRC_INIT;
    else if (cmd.key_in) key_r <= in_key;
    if (cmd.key_crc) pay_r <= PAYLOAD_WIDTH'(in_tag);
    if (cmd.n_load) n_r <= in_n;
    if (cmd.idx_clear) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + AW'(1);
    if (cmd.accept) evict_r <= 1'b0;
    else if (cmd.set_evict) evict_r <= 1'b1;
    if (cmd.note) begin
      note_status_r <= cmd.note_status;
      note_id_r     <= cmd.note_id;
    end
  end

  // entry memory: one read port, one write port
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  assign rd_en = cmd.rd_scan | cmd.rd_shift | cmd.rd_get;
  always_comb begin
    if (cmd.rd_shift) rd_addr = AW'(XW'(idx_r) + XW'(1));
    else if (cmd.rd_get) rd_addr = AW'(count_r - CW'(1) - CW'(n_r));
    else rd_addr = idx_r;
  end
  assign wr_en   = cmd.wr_shift | cmd.wr_append;
  assign wr_addr = cmd.wr_append ? AW'(count_r) : idx_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ids[wr_addr]  <= cmd.wr_append ? key_r : rd_id_r;
      pays[wr_addr] <= cmd.wr_append ? pay_r : rd_pay_r;
    end
    if (rd_en) begin
      rd_id_r  <= ids[rd_addr];
      rd_pay_r <= pays[rd_addr];
    end
  end

  // status to controller
  assign st.store_ready = ready_r;
  assign st.out_free    = !out_valid_r || out_tready;
  assign st.count_zero  = (count_r == '0);
  assign st.count_full  = (XW'(count_r) == XW'(DEPTH));
  assign st.idx_last    = (XW'(idx_r) + XW'(1) == XW'(count_r));
  assign st.shift_last  = (XW'(idx_r) + XW'(2) == XW'(count_r));
  assign st.match       = (rd_id_r == key_r);
  assign st.get_ok      = (10'(in_n) < 10'(count_r));

  // result beat
  logic [31:0] res_id, res_pay;
  always_comb begin
    case (note_id_r)
      ID_KEY: begin
        res_id  = key_r;
        res_pay = '0;
      end
      ID_RD: begin
        res_id  = rd_id_r;
        res_pay = 32'(rd_pay_r);
      end
      default: begin
        res_id  = '0;
        res_pay = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data_r <= {6'd0, evict_r, 7'(count_r), res_pay, res_id, note_status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
endmodule

// ----- tb/sv/dhs_scoreboard.sv -----
`timescale 1ns / 1ps
// checker: predicts the history store's results and compares them with the result beats
module dhs_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [87:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  output int          pending,
  output int          errors
);
  import dhs_pkg::*;

  localparam int NENT = 64;

  typedef struct {
    status_t     status;
    logic [31:0] id;
    logic [31:0] payload;
    logic [6:0]  count;
    logic        evicted;
  } store_result_t;

  store_result_t result_q[$];

  logic [31:0] crc_acc;
  logic [31:0] fp_mem[NENT];
  logic [31:0] tag_mem[NENT];
  int          n_stored;
  logic        ready_reg;

  // one byte of reflected crc-32
  function automatic logic [31:0] fold8(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
    return r;
  endfunction

  // drop entry at pos and close the gap
  task automatic squeeze(int pos);
    for (int i = pos; i + 1 < n_stored; i++) begin
      fp_mem[i]  = fp_mem[i + 1];
      tag_mem[i] = tag_mem[i + 1];
    end
    n_stored--;
  endtask

  // apply one input beat to the predicted store
  task automatic predict_store(logic [87:0] d);
    logic [2:0]    md;
    store_result_t r;
    logic          dup;
    int            pos;
    md = d[2:0];
    r.status = ST_DONE; r.id = '0; r.payload = '0; r.evicted = 1'b0;
    if (md == MODE_TEXT) begin
      crc_acc = fold8(crc_acc, d[10:3]);
      return;
    end
    if (md > MODE_CLEAR) begin
      r.status = ST_MISS;
    end else if (!ready_reg) begin
      r.status = ST_NRDY;
      if (md == MODE_COMMIT) crc_acc = 32'hFFFFFFFF;
    end else if (md == MODE_COMMIT) begin
      r.id = ~crc_acc;
      crc_acc = 32'hFFFFFFFF;
      dup = 1'b0;
      for (int i = 0; i < n_stored; i++) if (fp_mem[i] == r.id) dup = 1'b1;
      if (dup) begin
        r.status = ST_DUP;
      end else begin
        if (n_stored >= NENT) begin
          squeeze(0);
          r.evicted = 1'b1;
        end
        fp_mem[n_stored]  = r.id;
        tag_mem[n_stored] = d[42:11];
        n_stored++;
      end
    end else if (md == MODE_GET) begin
      if (int'(d[48:43]) >= n_stored) begin
        r.status = ST_MISS;
      end else begin
        pos = n_stored - 1 - int'(d[48:43]);
        r.id = fp_mem[pos];
        r.payload = tag_mem[pos];
      end
    end else if (md == MODE_REMOVE) begin
      r.status = ST_MISS;
      for (int i = 0; i < n_stored; i++) begin
        if (r.status == ST_MISS && fp_mem[i] == d[80:49]) begin
          squeeze(i);
          r.status = ST_DONE;
          r.id = d[80:49];
        end
      end
    end else begin
      n_stored = 0;
    end
    r.count = n_stored[6:0];
    result_q.push_back(r);
  endtask

  // compare result beat first, then predict from the input beat of the same edge
  always @(posedge clk) begin
    store_result_t e;
    int            nerr;
    nerr = 0;
    if (!rst_n) begin
      crc_acc   = 32'hFFFFFFFF;
      n_stored  = 0;
      ready_reg = 1'b0;
      result_q.delete();
      errors    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result beat %h", out_tdata);
          nerr++;
        end else begin
          e = result_q.pop_front();
          if (out_tdata[1:0] !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_tdata[1:0]);
            nerr++;
          end
          if (out_tdata[33:2] !== e.id) begin
            $error("out_id: expected %h actual %h", e.id, out_tdata[33:2]);
            nerr++;
          end
          if (out_tdata[65:34] !== e.payload) begin
            $error("out_payload: expected %h actual %h", e.payload, out_tdata[65:34]);
            nerr++;
          end
          if (out_tdata[72:66] !== e.count) begin
            $error("entry_count: expected %0d actual %0d", e.count, out_tdata[72:66]);
            nerr++;
          end
          if (out_tdata[73] !== e.evicted) begin
            $error("evicted: expected %0d actual %0d", e.evicted, out_tdata[73]);
            nerr++;
          end
        end
      end
      if (cfg_valid && cfg_ready) ready_reg = cfg_data;
      if (in_tvalid && in_tready) predict_store(in_tdata);
      errors <= errors + nerr;
    end
    pending <= result_q.size();
  end
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// top of the testbench: clock, reset, stimulus and verdict for the history store
module testbench;
  import dhs_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // mode[2:0], data_byte[10:3], payload_tag[42:11], newest_index[48:43], key_id[80:49]
  logic [87:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // status[1:0], out_id[33:2], out_payload[65:34], entry_count[72:66], evicted[73]
  logic [79:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  int          pending;
  int          errors;

  int          burst_left = 0;
  int          commits_sent = 0;
  int          evictions = 0;
  int          edge_count = 0;
  logic [31:0] known_ids[$];
  logic [31:0] msg_text[$];
  int          msg_len[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  dedup_history_store_crc32_top dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .cfg_valid, .cfg_ready, .cfg_data
  );

  dhs_scoreboard chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .cfg_valid, .cfg_ready, .cfg_data,
    .pending, .errors
  );

  // receiver stall pattern: long clean stretches, otherwise random stalls
  always @(posedge clk) begin
    edge_count <= edge_count + 1;
    out_tready <= (edge_count[9:8] == 2'd0) ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  // collect fingerprints seen on the result side as remove keys
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (out_tdata[33:2] != 0 && out_tdata[1:0] != ST_NRDY) known_ids.push_back(out_tdata[33:2]);
      if (out_tdata[73]) evictions++;
    end
  end

  // one input beat, with bursts and gaps
  task automatic send_beat(logic [2:0] md, logic [7:0] b, logic [31:0] tag,
                           logic [5:0] nidx, logic [31:0] key);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, key, nidx, tag, b, md};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    if (md == MODE_COMMIT) commits_sent++;
  endtask

  task automatic send_op(logic [2:0] md);
    send_beat(md, 8'($urandom()), $urandom(), 6'($urandom()), $urandom());
  endtask

  // text bytes of a message followed by its commit
  task automatic send_message(logic [31:0] txt, int len, logic [31:0] tag);
    for (int i = 0; i < len; i++) begin
      send_beat(MODE_TEXT, txt[8*i +: 8], $urandom(), 6'($urandom()), $urandom());
    end
    send_beat(MODE_COMMIT, 8'($urandom()), tag, 6'($urandom()), $urandom());
  endtask

  task automatic new_message(logic [31:0] tag);
    logic [31:0] t;
    int          n;
    t = $urandom();
    n = $urandom_range(1, 4);
    msg_text.push_back(t);
    msg_len.push_back(n);
    send_message(t, n, tag);
  endtask

  // sender stops until every expected result is back and the block has settled
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_ready(logic v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random mix: mostly well-formed messages, some table ops and noise
  task automatic random_phase(int n_items);
    int sel;
    int k;
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) new_message($urandom());
      else if (sel < 55 && msg_text.size() > 0) begin
        k = $urandom_range(0, msg_text.size() - 1);
        send_message(msg_text[k], msg_len[k], $urandom());
      end else if (sel < 70) send_beat(MODE_GET, 8'($urandom()), $urandom(),
                                       ($urandom_range(0, 8) == 0) ? 6'($urandom()) :
                                                                     6'($urandom_range(0, 20)),
                                       $urandom());
      else if (sel < 82 && known_ids.size() > 0)
        send_beat(MODE_REMOVE, 8'($urandom()), $urandom(), 6'($urandom()),
                  known_ids[$urandom_range(0, known_ids.size() - 1)]);
      else if (sel < 88) send_op(MODE_REMOVE);
      else if (sel < 90) send_op(MODE_CLEAR);
      else if (sel < 94) send_beat(3'($urandom_range(5, 7)), 8'($urandom()), $urandom(),
                                   6'($urandom()), $urandom());
      else if (sel < 97) send_op(MODE_TEXT);
      else send_op(MODE_COMMIT);
    end
  endtask

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // not ready: every table op answers not ready, text still folds
    write_ready(1'b0);
    send_beat(MODE_TEXT, 8'hFF, '0, '0, '0);
    send_beat(MODE_COMMIT, 8'h00, 32'hFFFFFFFF, '0, '0);
    send_op(MODE_GET);
    send_op(MODE_REMOVE);
    send_op(MODE_CLEAR);
    send_beat(3'd7, 8'hFF, 32'hFFFFFFFF, 6'h3F, 32'hFFFFFFFF);

    // ready: directed corner cases
    write_ready(1'b1);
    send_op(MODE_CLEAR);
    send_beat(MODE_GET, '0, '0, 6'd0, '0);
    send_beat(MODE_REMOVE, '0, '0, '0, 32'hFFFFFFFF);
    send_message(32'h0, 0, 32'h0);
    send_message(32'h0, 0, 32'hFFFFFFFF);
    send_message(32'h000000FF, 1, 32'hFFFFFFFF);
    send_message(32'hFF00AA55, 4, 32'h12345678);
    send_beat(MODE_GET, '0, '0, 6'd0, '0);
    send_beat(MODE_GET, '0, '0, 6'd2, '0);
    send_beat(MODE_GET, '0, '0, 6'd3, '0);
    send_beat(MODE_GET, '0, '0, 6'h3F, '0);
    send_beat(MODE_REMOVE, '0, '0, '0, 32'h0);
    send_beat(3'd5, '0, '0, '0, '0);
    send_beat(3'd6, '0, '0, '0, '0);
    send_op(MODE_CLEAR);
    drain();

    // fill past the depth with one-byte messages to force evictions
    for (int i = 0; i < 70; i++) begin
      msg_text.push_back(i);
      msg_len.push_back(1);
      send_message(i, 1, $urandom());
    end
    send_beat(MODE_GET, '0, '0, 6'h3F, '0);
    random_phase(40);
    drain();
    random_phase(20);

    // back to not ready for a while, then ready again
    write_ready(1'b0);
    random_phase(10);
    write_ready(1'b1);
    random_phase(30);
    in_tvalid <= 1'b0;

    drain();
    $display("covered %0d commits, %0d evictions, both settings of store_ready,",
             commits_sent, evictions);
    $display("reads, removes, clears, unknown modes and stalls on both sides");
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
